// ===== rtl/wildcard_byte_pattern_search_core_defines.svh =====
// assertion macros shared by the wildcard byte pattern search rtl
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_CORE_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WBPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wbps assertion failed");

// next-cycle implication, checked outside reset
`define WBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wbps assertion failed");

`endif

// ===== rtl/wbps_pkg.sv =====
// types and constants of the wildcard byte pattern search block
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int BYTE_W       = 8;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_OFFSET_W = 24;

  // item kinds carried on in_tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CODE = 1'b1;

  // control from the top level to the pattern/window unit
  typedef struct packed {
    logic              load_shift;
    logic              code_shift;
    logic [BYTE_W-1:0] value;
    logic              wild;
  } scan_cmd_t;

endpackage

// ===== rtl/wbps_scan.sv =====
// pattern and code byte shift registers with parallel masked compare
`timescale 1ns / 1ps

module wbps_scan #(
  parameter int PATTERN_MAX = 32,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic               clk,
  input  wbps_pkg::scan_cmd_t cmd,
  input  logic [LEN_W-1:0]   len,
  output logic               hit
);
  import wbps_pkg::*;

  // pattern is shifted in, so entry k lines up with window entry k
  logic [BYTE_W-1:0] pat_byte_r [PATTERN_MAX];
  logic              pat_wild_r [PATTERN_MAX];
  logic [BYTE_W-1:0] win_r      [PATTERN_MAX];
  logic [BYTE_W-1:0] win_nxt    [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hit_vec;

  always_comb begin
    win_nxt[0] = cmd.value;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_shift) begin
      pat_byte_r[0] <= cmd.value;
      pat_wild_r[0] <= cmd.wild;
      for (int k = 1; k < PATTERN_MAX; k++) begin
        pat_byte_r[k] <= pat_byte_r[k-1];
        pat_wild_r[k] <= pat_wild_r[k-1];
      end
    end
    if (cmd.code_shift) begin
      win_r <= win_nxt;
    end
  end

  // entries at or beyond the pattern length never block a match
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      hit_vec[k] = (LEN_W'(k) >= len) || pat_wild_r[k] || (pat_byte_r[k] == win_nxt[k]);
    end
  end

  assign hit = &hit_vec;

endmodule

// ===== rtl/wildcard_byte_pattern_search_core.sv =====
// top level of the wildcard byte pattern search block
`timescale 1ns / 1ps
// wildcard byte pattern search
// in_* stream: in_tuser selects a pattern entry (0) or a code byte (1),
// in_tdata carries the byte and the wildcard flag, in_tlast ends the
// pattern load or the code run. a pattern entry that follows a finished
// load starts a new pattern; up to PATTERN_MAX entries are kept.
// out_* stream: one result item per code byte flagged last, giving found
// and the offset of the first match start (zero when nothing matched).
// throughput: one item per cycle unless a second result waits on out_tready, set by the single
// compare stage of a shift window against the shifted-in pattern.
// result path: a last code byte is taken into the input register, which feeds
// the compare, which loads the result register that drives out_tvalid.
// reset clears pattern length, scan count and both pipeline valids; the
// pattern contents are not cleared. while out_tvalid waits on out_tready,
// items that produce no result keep flowing; a second result stalls the
// input register, which drops in_tready.

module wildcard_byte_pattern_search_core #(
  parameter int PATTERN_MAX = 32,
  parameter int OFFSET_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [wbps_pkg::IN_TDATA_W-1:0]  in_tdata,   // byte_value[7:0], is_wildcard[8]
  input  logic                             in_tuser,   // func
  input  logic                             in_tlast,   // is_last
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wbps_pkg::OUT_TDATA_W-1:0] out_tdata   // found[0], match_offset[24:1]
);
  import wbps_pkg::*;
  `include "wildcard_byte_pattern_search_core_defines.svh"

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

  // input register
  logic              s1_valid_r;
  logic              s1_func_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_wild_r;
  logic              s1_last_r;

  // scan state
  logic [LEN_W-1:0]       len_r, len_nxt, len_base;
  logic                   loading_r, loading_nxt;
  logic [OFFSET_BITS-1:0] count_r, count_nxt, count_inc, len_ext;
  logic                   seen_r, seen_nxt, seen_upd;
  logic [OFFSET_BITS-1:0] first_r, first_nxt, first_upd;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r, out_found_nxt;
  logic [OUT_OFFSET_W-1:0] out_offset_r, out_offset_nxt;
  logic [OFFSET_BITS+OUT_OFFSET_W-1:0] offset_ext;

  logic      produces, s1_go, is_load, is_code, hit, count_room, new_match;
  scan_cmd_t cmd;

  assign produces  = (s1_func_r == FUNC_CODE) && s1_last_r;
  assign s1_go     = s1_valid_r && (!produces || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign is_load   = s1_go && (s1_func_r == FUNC_LOAD);
  assign is_code   = s1_go && (s1_func_r == FUNC_CODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_func_r <= in_tuser;
      s1_byte_r <= in_tdata[BYTE_W-1:0];
      s1_wild_r <= in_tdata[BYTE_W];
      s1_last_r <= in_tlast;
    end
  end

  // a load that follows a finished one starts from length zero
  assign len_base = loading_r ? len_r : '0;

  always_comb begin
    cmd.load_shift = is_load && (len_base < LEN_MAX);
    cmd.code_shift = is_code;
    cmd.value      = s1_byte_r;
    cmd.wild       = s1_wild_r;
  end

  wbps_scan #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W)
  ) u_scan (
    .clk (clk),
    .cmd (cmd),
    .len (len_r),
    .hit (hit)
  );

  assign count_room = (count_r != COUNT_MAX);
  assign count_inc  = count_r + OFFSET_BITS'(1);
  assign len_ext    = OFFSET_BITS'(len_r);
  assign new_match  = (len_r == '0) || ((count_inc >= len_ext) && hit);

  always_comb begin
    seen_upd  = seen_r;
    first_upd = first_r;
    if (count_room && !seen_r && new_match) begin
      seen_upd  = 1'b1;
      first_upd = (len_r == '0) ? '0 : (count_inc - len_ext);
    end
  end

  assign offset_ext = {{OUT_OFFSET_W{1'b0}}, first_upd};

  always_comb begin
    len_nxt        = len_r;
    loading_nxt    = loading_r;
    count_nxt      = count_r;
    seen_nxt       = seen_r;
    first_nxt      = first_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_offset_nxt = out_offset_r;
    if (is_load) begin
      if (!loading_r) begin
        count_nxt = '0;
        seen_nxt  = 1'b0;
        first_nxt = '0;
      end
      len_nxt     = cmd.load_shift ? len_base + LEN_W'(1) : len_base;
      loading_nxt = !s1_last_r;
    end else if (is_code) begin
      loading_nxt = 1'b0;
      if (count_room) begin
        count_nxt = count_inc;
      end
      seen_nxt  = seen_upd;
      first_nxt = first_upd;
      if (s1_last_r) begin
        out_valid_nxt  = 1'b1;
        out_found_nxt  = seen_upd;
        out_offset_nxt = seen_upd ? offset_ext[OUT_OFFSET_W-1:0] : '0;
        count_nxt      = '0;
        seen_nxt       = 1'b0;
        first_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      loading_r   <= 1'b0;
      count_r     <= '0;
      seen_r      <= 1'b0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      loading_r   <= loading_nxt;
      count_r     <= count_nxt;
      seen_r      <= seen_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_OFFSET_W - 1){1'b0}}, out_offset_r, out_found_r};

  `WBPS_ASSERT_IMP(a_len_bounded, clk, rst_n, 1'b1, len_r <= LEN_MAX)
  `WBPS_ASSERT_IMP(a_not_found_zero, clk, rst_n, out_valid_r && !out_found_r,
                   out_offset_r == '0)
  `WBPS_ASSERT_NEXT(a_scan_cleared, clk, rst_n, is_code && s1_last_r,
                    (count_r == '0) && !seen_r && out_valid_r)
  `WBPS_ASSERT_NEXT(a_s1_held, clk, rst_n, s1_valid_r && !s1_go,
                    s1_valid_r && $stable(s1_func_r) && $stable(s1_byte_r) && $stable(s1_last_r))

endmodule
